[rtl/core/assert_macros.svh]
// assertion macros used by the checker file trsc_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, disabled while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds during reset
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/trsc_pkg.sv]
// shared types, sizes and codes for the tiny rv32 subset core
// no dependencies
package trsc_pkg;

  localparam int MEM_WORDS = 1024;
  localparam int REG_COUNT = 32;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int RF_AW     = $clog2(REG_COUNT);

  localparam logic [29:0] MEM_WORDS_PC = 30'(MEM_WORDS);
  localparam logic [31:0] MEM_WORDS_LD = 32'(MEM_WORDS);
  localparam logic [5:0]  REG_LIM      = 6'(REG_COUNT);

  // rv32 major opcodes that the core executes
  localparam logic [6:0] OP_ADDI = 7'h13;
  localparam logic [6:0] OP_JALR = 7'h67;
  localparam logic [6:0] OP_ADD  = 7'h33;
  localparam logic [6:0] OP_LUI  = 7'h37;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_PC_RANGE    = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } status_t;

  typedef struct packed {
    logic              wr_en;
    logic [MEM_AW-1:0] addr;
    logic [31:0]       wdata;
    logic              clear;
  } imem_req_t;

  typedef struct packed {
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [31:0] wr_data;
    logic        clear;
    logic [4:0]  rd_idx_a;
    logic [4:0]  rd_idx_b;
  } rf_req_t;

  function automatic logic reg_ok(input logic [4:0] idx);
    reg_ok = {1'b0, idx} < REG_LIM;
  endfunction

endpackage

[rtl/core/trsc_imem.sv]
// instruction memory: single port, registered read, zeroing sweep
// depends on trsc_pkg
module trsc_imem (
  input  logic                clk,
  input  logic                rst,
  input  trsc_pkg::imem_req_t req,
  output logic [31:0]         rdata,
  output logic                busy
);
  import trsc_pkg::*;

  logic [31:0]       mem [MEM_WORDS];
  logic [MEM_AW-1:0] sweep;

  // sweep control
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      busy  <= 1'b1;
      sweep <= '0;
    end else if (busy) begin
      if (sweep == MEM_AW'(MEM_WORDS - 1)) begin
        busy <= 1'b0;
      end
      sweep <= sweep + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

[rtl/core/trsc_regfile.sv]
// register file: one write port, two registered read ports, valid bits
// depends on trsc_pkg
module trsc_regfile (
  input  logic              clk,
  input  logic              rst,
  input  trsc_pkg::rf_req_t req,
  output logic [31:0]       rdata_a,
  output logic [31:0]       rdata_b
);
  import trsc_pkg::*;

  logic [31:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [31:0]          data_a;
  logic [31:0]          data_b;
  logic                 hit_a;
  logic                 hit_b;

  // entries not written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[RF_AW'(req.wr_idx)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[RF_AW'(req.wr_idx)] <= req.wr_data;
    end
    data_a <= mem[RF_AW'(req.rd_idx_a)];
    data_b <= mem[RF_AW'(req.rd_idx_b)];
    hit_a  <= reg_ok(req.rd_idx_a) && valid[RF_AW'(req.rd_idx_a)] && !req.clear;
    hit_b  <= reg_ok(req.rd_idx_b) && valid[RF_AW'(req.rd_idx_b)] && !req.clear;
  end

  assign rdata_a = hit_a ? data_a : '0;
  assign rdata_b = hit_b ? data_b : '0;

endmodule

[rtl/core/tiny_riscv_subset_core.sv]
// step items pass through decode, exec, report and finish; load, reset, clear and
// pc-outside-memory step items go from accept straight to report and finish
// the result enters the output register from finish once the output is free
// one item in flight: a new item is taken only after finish returns to idle
// clear memory and reset both run a zeroing sweep over all MEM_WORDS (1024) imem words,
// during which in_ready stays low; reset also zeroes pc, regfile and the output valid
module tiny_riscv_subset_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [9:0]  word_address,
  input  logic [31:0] instr_word,
  input  logic [4:0]  reg_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] pc_value,
  output logic        reg_written,
  output logic [4:0]  written_index,
  output logic [31:0] written_value,
  output logic [31:0] reg_value
);
  import trsc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_EXEC   = 5'b00100,
    S_REPORT = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t      state;
  logic [31:0] pc;
  logic [31:0] instr;
  logic [4:0]  sel;

  // result fields gathered while the item runs
  logic [1:0]  res_status;
  logic        res_wr;
  logic [4:0]  res_idx;
  logic [31:0] res_val;

  imem_req_t   imem_req;
  rf_req_t     rf_req;
  logic [31:0] imem_rdata;
  logic        imem_busy;
  logic [31:0] rf_a;
  logic [31:0] rf_b;

  logic        in_acc;
  logic        pc_ok;
  logic        waddr_ok;
  logic        out_free;

  // decode fields of the held instruction
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [6:0]  f7;
  logic [31:0] imm;
  logic [31:0] sum;
  logic [31:0] pc_plus4;
  logic [31:0] wval;
  logic [31:0] pc_target;
  logic        bad;

  trsc_imem u_imem (
    .clk   (clk),
    .rst   (rst),
    .req   (imem_req),
    .rdata (imem_rdata),
    .busy  (imem_busy)
  );

  trsc_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .req     (rf_req),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  // one item in flight; the output register frees the input side
  assign in_ready = (state == S_IDLE) && !imem_busy;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign pc_ok    = pc[31:2] < MEM_WORDS_PC;
  assign waddr_ok = {22'd0, word_address} < MEM_WORDS_LD;

  // imem: load writes at accept, step reads the word at pc/4 at accept
  always_comb begin
    imem_req.wr_en = in_acc && (opcode == CMD_LOAD) && waddr_ok;
    imem_req.addr  = imem_req.wr_en ? MEM_AW'({22'd0, word_address}) : MEM_AW'(pc[31:2]);
    imem_req.wdata = instr_word;
    imem_req.clear = in_acc && (opcode == CMD_CLEAR);
  end

  assign op  = instr[6:0];
  assign rd  = instr[11:7];
  assign f3  = instr[14:12];
  assign rs1 = instr[19:15];
  assign rs2 = instr[24:20];
  assign f7  = instr[31:25];
  assign imm = {{20{instr[31]}}, instr[31:20]};

  // one shared adder: rs1 + rs2 for add, rs1 + imm for addi and jalr
  assign sum       = rf_a + ((op == OP_ADD) ? rf_b : imm);
  assign pc_plus4  = pc + 32'd4;
  assign pc_target = (op == OP_JALR) ? {sum[31:1], 1'b0} : pc_plus4;

  always_comb begin
    bad  = 1'b0;
    wval = sum;
    case (op)
      OP_ADDI: begin
        bad = (f3 != 3'd0) || !reg_ok(rd) || !reg_ok(rs1);
      end
      OP_JALR: begin
        bad  = (f3 != 3'd0) || !reg_ok(rd) || !reg_ok(rs1);
        wval = pc_plus4;
      end
      OP_ADD: begin
        bad = (f3 != 3'd0) || (f7 != 7'd0) || !reg_ok(rd) || !reg_ok(rs1) || !reg_ok(rs2);
      end
      OP_LUI: begin
        bad  = !reg_ok(rd);
        wval = {instr[31:12], 12'd0};
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  // regfile: operands read in decode, write-back in exec, selected reg read in report.
  // the write lands at the end of exec, before the report read, so no forwarding is needed
  always_comb begin
    rf_req.wr_en    = (state == S_EXEC) && !bad && (rd != 5'd0);
    rf_req.wr_idx   = rd;
    rf_req.wr_data  = wval;
    rf_req.clear    = in_acc && (opcode == CMD_RESET);
    rf_req.rd_idx_a = (state == S_DECODE) ? imem_rdata[19:15] : sel;
    rf_req.rd_idx_b = imem_rdata[24:20];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (opcode == CMD_STEP && pc_ok) begin
              state <= S_DECODE;
            end else begin
              state <= S_REPORT;
            end
            if (opcode == CMD_RESET) begin
              pc <= '0;
            end
          end
        end
        S_DECODE: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (!bad) begin
            pc <= pc_target;
          end
          state <= S_REPORT;
        end
        S_REPORT: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item payload and result fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sel        <= reg_select;
      res_wr     <= 1'b0;
      res_idx    <= '0;
      res_val    <= '0;
      res_status <= (opcode == CMD_STEP && !pc_ok) ? ST_PC_RANGE : ST_OK;
    end
    if (state == S_DECODE) begin
      instr <= imem_rdata;
    end
    if (state == S_EXEC) begin
      if (bad) begin
        res_status <= ST_UNSUPPORTED;
      end else begin
        res_status <= ST_OK;
        res_wr     <= 1'b1;
        res_idx    <= rd;
        res_val    <= (rd == 5'd0) ? 32'd0 : wval;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      status        <= res_status;
      pc_value      <= pc;
      reg_written   <= res_wr;
      written_index <= res_idx;
      written_value <= res_val;
      reg_value     <= rf_a;
    end
  end

endmodule

[rtl/core/trsc_checker.sv]
// port-level checks for the tiny rv32 subset core, bound to the top level
// depends on trsc_pkg and assert_macros.svh
`include "assert_macros.svh"

module trsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic [4:0]  reg_select,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] pc_value,
  input logic        reg_written,
  input logic [4:0]  written_index,
  input logic [31:0] written_value,
  input logic [31:0] reg_value
);
  import trsc_pkg::*;

  property p_out_hold;
    out_valid && !out_ready |=>
      out_valid && $stable(pc_value) && $stable(reg_value) && $stable(status);
  endproperty

  property p_err_nowrite;
    out_valid && status != ST_OK |->
      !reg_written && written_index == 5'd0 && written_value == 32'd0;
  endproperty

  property p_x0_zero;
    out_valid && reg_written && written_index == 5'd0 |-> written_value == 32'd0;
  endproperty

  property p_status_code;
    out_valid |-> status == ST_OK || status == ST_PC_RANGE || status == ST_UNSUPPORTED;
  endproperty

  // reset empties the output and starts the imem sweep
  `CHK_ASSERT_NR(a_rst_idle, clk, rst |=> !out_valid && !in_ready, "reset must block both sides")

  // a stalled result holds
  `CHK_ASSERT(a_out_hold, clk, rst, p_out_hold, "stalled result changed")

  // a failed step writes nothing
  `CHK_ASSERT(a_err_nowrite, clk, rst, p_err_nowrite, "failed item reports a write")

  // x0 writes report zero
  `CHK_ASSERT(a_x0_zero, clk, rst, p_x0_zero, "x0 write value not zero")

  // status stays within its codes
  `CHK_ASSERT(a_status_code, clk, rst, p_status_code, "bad status code")

endmodule

bind tiny_riscv_subset_core trsc_checker u_trsc_checker (.*);

[tb/tb.sv]
// self-checking testbench for the tiny rv32 subset core (addi, add, lui, jalr)
// keeps its own model of pc, regfile and imem and checks every result item in order
// depends on trsc_pkg and tiny_riscv_subset_core
`timescale 1ns / 1ps

module tb;
  import trsc_pkg::*;

  // one expected or observed result item
  typedef struct packed {
    status_t     status;
    logic [31:0] pc;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic [31:0] rval;
  } core_result_t;

  // receiver stall patterns
  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = CMD_STEP;
  logic [9:0]  word_address = '0;
  logic [31:0] instr_word = '0;
  logic [4:0]  reg_select = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] pc_value;
  logic        reg_written;
  logic [4:0]  written_index;
  logic [31:0] written_value;
  logic [31:0] reg_value;

  tiny_riscv_subset_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .word_address(word_address),
    .instr_word(instr_word), .reg_select(reg_select),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .pc_value(pc_value),
    .reg_written(reg_written), .written_index(written_index),
    .written_value(written_value), .reg_value(reg_value)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the architectural state
  logic [31:0] core_pc;
  logic [31:0] core_rf [REG_COUNT];
  logic [31:0] core_imem [MEM_WORDS];

  // expected result items, oldest first
  core_result_t result_q[$];

  int err_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit hold_start = 1'b0;
  int hold_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int rx_left = 0;
  int rx_phase = 0;

  function automatic bit reg_fits(logic [4:0] idx);
    return int'(idx) < REG_COUNT;
  endfunction

  // x0 and registers past the file read as zero
  function automatic logic [31:0] rf_read(logic [4:0] idx);
    if (idx == 5'd0 || !reg_fits(idx)) return 32'd0;
    return core_rf[idx];
  endfunction

  // apply one item to the shadow state and return the result it should give
  function automatic core_result_t predict_item(cmd_t cmd, logic [9:0] addr,
                                                logic [31:0] word, logic [4:0] sel);
    core_result_t r;
    logic [31:0] fetch_idx, w, imm, val, next_pc;
    logic [6:0]  op, f7;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    bit          bad;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_STEP: begin
        fetch_idx = core_pc >> 2;
        if (fetch_idx >= 32'(MEM_WORDS)) begin
          r.status = ST_PC_RANGE;
        end else begin
          w = core_imem[fetch_idx];
          op = w[6:0];
          rd = w[11:7];
          f3 = w[14:12];
          rs1 = w[19:15];
          rs2 = w[24:20];
          f7 = w[31:25];
          imm = {{20{w[31]}}, w[31:20]};
          next_pc = core_pc + 32'd4;
          val = 32'd0;
          bad = 1'b0;
          case (op)
            OP_ADDI: begin
              bad = f3 != 3'd0 || !reg_fits(rd) || !reg_fits(rs1);
              val = rf_read(rs1) + imm;
            end
            OP_JALR: begin
              bad = f3 != 3'd0 || !reg_fits(rd) || !reg_fits(rs1);
              next_pc = (rf_read(rs1) + imm) & ~32'd1;
              val = core_pc + 32'd4;
            end
            OP_ADD: begin
              bad = f3 != 3'd0 || f7 != 7'd0 || !reg_fits(rd) || !reg_fits(rs1)
                    || !reg_fits(rs2);
              val = rf_read(rs1) + rf_read(rs2);
            end
            OP_LUI: begin
              bad = !reg_fits(rd);
              val = w & 32'hfffff000;
            end
            default: bad = 1'b1;
          endcase
          if (bad) begin
            r.status = ST_UNSUPPORTED;
          end else begin
            if (rd == 5'd0) val = 32'd0;
            else core_rf[rd] = val;
            core_pc = next_pc;
            r.wr = 1'b1;
            r.widx = rd;
            r.wval = val;
          end
        end
      end
      CMD_LOAD: begin
        if (int'(addr) < MEM_WORDS) core_imem[addr] = word;
      end
      CMD_RESET: begin
        core_pc = 32'd0;
        foreach (core_rf[i]) core_rf[i] = 32'd0;
      end
      default: begin
        foreach (core_imem[i]) core_imem[i] = 32'd0;
      end
    endcase
    r.pc = core_pc;
    r.rval = rf_read(sel);
    return r;
  endfunction

  // instruction encoders
  function automatic logic [31:0] enc_i(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                        logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  // mostly low registers so that instructions feed each other
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
  endfunction

  // mostly legal instructions; most jalr targets land inside a program of n words
  function automatic logic [31:0] random_instr(int n);
    logic [4:0]  rd, rs1, rs2;
    logic [11:0] imm;
    int          kind;
    rd = pick_reg();
    rs1 = pick_reg();
    rs2 = pick_reg();
    imm = 12'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 30) return enc_i(OP_ADDI, rd, 3'd0, rs1, imm);
    if (kind < 55) return enc_r(7'd0, rs2, rs1, 3'd0, rd, OP_ADD);
    if (kind < 68) return {20'($urandom), rd, OP_LUI};
    if (kind < 80)
      return enc_i(OP_JALR, rd, 3'd0, 5'd0,
                   12'(4 * $urandom_range(0, n - 1) + $urandom_range(0, 3)));
    if (kind < 84) return enc_i(OP_JALR, rd, 3'd0, rs1, imm);
    // broken funct3 on an i-type
    if (kind < 88)
      return enc_i($urandom_range(0, 1) ? OP_ADDI : OP_JALR, rd,
                   3'($urandom_range(1, 7)), rs1, imm);
    // broken funct7 on add
    if (kind < 92) return enc_r(7'($urandom_range(1, 127)), rs2, rs1, 3'($urandom), rd, OP_ADD);
    return $urandom;
  endfunction

  // offer one item, hold it until accepted, then record what it should produce;
  // the sender works in bursts with random gaps in between
  task automatic send_item(cmd_t cmd, logic [9:0] addr, logic [31:0] word, logic [4:0] sel);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    opcode <= cmd;
    word_address <= addr;
    instr_word <= word;
    reg_select <= sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    result_q.push_back(predict_item(cmd, addr, word, sel));
  endtask

  // stop offering and wait until every expected item is back, plus the tail latency
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // extremes of the fields, every command and each corner of the decoder
  task automatic test_directed();
    // addi with imm all ones, add of that, lui into the top register
    send_item(CMD_LOAD, 10'd0, enc_i(OP_ADDI, 5'd1, 3'd0, 5'd0, 12'hfff), 5'd0);
    send_item(CMD_LOAD, 10'd1, enc_r(7'd0, 5'd1, 5'd1, 3'd0, 5'd2, OP_ADD), 5'd31);
    send_item(CMD_LOAD, 10'd2, {20'hfffff, 5'd31, OP_LUI}, 5'd0);
    // write to x0 is reported but x0 stays zero
    send_item(CMD_LOAD, 10'd3, enc_i(OP_ADDI, 5'd0, 3'd0, 5'd1, 12'd5), 5'd0);
    // jalr to an odd target: bit 0 dropped, pc ends up unaligned
    send_item(CMD_LOAD, 10'd4, enc_i(OP_JALR, 5'd5, 3'd0, 5'd0, 12'd23), 5'd0);
    // add with a nonzero funct7 is not supported
    send_item(CMD_LOAD, 10'd5, enc_r(7'h20, 5'd2, 5'd1, 3'd0, 5'd3, OP_ADD), 5'd0);
    send_item(CMD_STEP, 10'd0, 32'd0, 5'd1);
    send_item(CMD_STEP, 10'd0, 32'd0, 5'd2);
    send_item(CMD_STEP, 10'd0, 32'd0, 5'd31);
    send_item(CMD_STEP, 10'd0, 32'd0, 5'd0);
    send_item(CMD_STEP, 10'd0, 32'd0, 5'd5);
    send_item(CMD_STEP, 10'd0, 32'd0, 5'd3);
    // jump far above the memory, then the next fetch is out of range
    send_item(CMD_LOAD, 10'd5, enc_i(OP_JALR, 5'd6, 3'd0, 5'd31, 12'h7ff), 5'd0);
    send_item(CMD_STEP, 10'd0, 32'd0, 5'd6);
    send_item(CMD_STEP, 10'd0, 32'd0, 5'd31);
    // cpu reset keeps memory, clears pc and registers
    send_item(CMD_RESET, 10'h3ff, 32'hffffffff, 5'd31);
    send_item(CMD_LOAD, 10'h3ff, 32'hffffffff, 5'd31);
    send_item(CMD_LOAD, 10'd0, 32'h00000000, 5'd0);
    send_item(CMD_STEP, 10'd0, 32'd0, 5'd0);
    // addi with a bad funct3
    send_item(CMD_LOAD, 10'd0, enc_i(OP_ADDI, 5'd1, 3'd7, 5'd0, 12'd1), 5'd1);
    send_item(CMD_STEP, 10'd0, 32'd0, 5'd1);
    // clear memory, then word 0 is zero again and fails to decode
    send_item(CMD_CLEAR, 10'h3ff, 32'hffffffff, 5'd0);
    send_item(CMD_STEP, 10'h3ff, 32'hffffffff, 5'd31);
  endtask

  // short random programs: reset the cpu, load a few words, run a few steps
  task automatic test_programs();
    int n, steps;
    for (int p = 0; p < 22; p++) begin
      if ($urandom_range(0, 11) == 0)
        send_item(CMD_CLEAR, 10'($urandom), $urandom, 5'($urandom));
      send_item(CMD_RESET, 10'($urandom), $urandom, 5'($urandom));
      n = $urandom_range(2, 8);
      for (int i = 0; i < n; i++)
        send_item(CMD_LOAD, 10'(i), random_instr(n), 5'($urandom));
      steps = $urandom_range(n, 2 * n + 2);
      for (int i = 0; i < steps; i++)
        send_item(CMD_STEP, 10'($urandom), $urandom, 5'($urandom));
      if ($urandom_range(0, 5) == 0) wait_idle();
    end
  endtask

  // receiver holds off for a long stretch while items keep coming back to back,
  // then the sender waits for everything to drain
  task automatic test_backpressure();
    bit saved_gaps;
    saved_gaps = gaps_on;
    gaps_on = 1'b0;
    hold_start = 1'b1;
    send_item(CMD_RESET, 10'($urandom), $urandom, 5'($urandom));
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) send_item(CMD_LOAD, 10'(i / 3), random_instr(8), 5'($urandom));
      else send_item(CMD_STEP, 10'($urandom), $urandom, 5'($urandom));
    end
    wait_idle();
    gaps_on = saved_gaps;
  endtask

  // loose mix of all commands with arbitrary addresses and words
  task automatic test_noise();
    cmd_t        cmd;
    int          pick;
    logic [9:0]  addr;
    logic [31:0] word;
    for (int i = 0; i < 60; i++) begin
      pick = $urandom_range(0, 99);
      cmd = pick < 45 ? CMD_STEP : pick < 85 ? CMD_LOAD : pick < 97 ? CMD_RESET : CMD_CLEAR;
      addr = $urandom_range(0, 1) ? 10'($urandom_range(0, 7)) : 10'($urandom);
      word = $urandom_range(0, 1) ? random_instr(8) : $urandom;
      send_item(cmd, addr, word, 5'($urandom));
    end
  endtask

  // compare each accepted result item with the oldest expectation
  always @(posedge clk) begin : result_checker
    core_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{status_t'(status), pc_value, reg_written, written_index, written_value,
              reg_value};
      if (result_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: st=%0d pc=%h wr=%0d wi=%0d wv=%h rv=%h",
                   got.status, got.pc, got.wr, got.widx, got.wval, got.rval);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch exp: st=%0d pc=%h wr=%0d wi=%0d wv=%h rv=%h",
                     want.status, want.pc, want.wr, want.widx, want.wval, want.rval);
            $display("         got: st=%0d pc=%h wr=%0d wi=%0d wv=%h rv=%h",
                     got.status, got.pc, got.wr, got.widx, got.wval, got.rval);
          end
        end
      end
    end
  end

  // receiver stall pattern: a new random mode is drawn whenever the current one runs out,
  // a requested hold-off keeps ready low for a long counted stretch
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
          RX_FREE: out_ready <= 1'b1;
          RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (rx_phase % 4 == 0);
        endcase
      end
    end
  end

  // main sequence
  initial begin
    core_pc = 32'd0;
    foreach (core_rf[i]) core_rf[i] = 32'd0;
    foreach (core_imem[i]) core_imem[i] = 32'd0;
    // hold reset, then release it; the core then sweeps imem with in_ready low
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    wait_idle();
    test_programs();
    test_backpressure();
    test_noise();
    wait_idle();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/trsc_pkg.sv
rtl/core/trsc_imem.sv
rtl/core/trsc_regfile.sv
rtl/core/tiny_riscv_subset_core.sv
rtl/core/trsc_checker.sv
tb/tb.sv
